### rtl/aes_cfb_pkg.sv
package aes_cfb_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEYX,
    ST_INIT,
    ST_ROUND,
    ST_OUT
  } aes_state_t;

  typedef struct packed {
    logic       load_in;
    logic       key_start;
    logic       key_step;
    logic       blk_init;
    logic       blk_round;
    logic       finish;
  } aes_cmd_t;

  typedef struct packed {
    logic       first;
    logic       key_last;
    logic       round_last;
  } aes_stat_t;

  localparam logic [3:0] LastRound = 4'd14;
  localparam logic [5:0] LastKeyWord = 6'd59;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

### rtl/aes_cfb_ctrl.sv
module aes_cfb_ctrl
  import aes_cfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  aes_stat_t stat,
  output aes_cmd_t  cmd
);

  aes_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        // first word of a message expands the key before the rounds
        if (stat.first) begin
          cmd.key_start = 1'b1;
          state_next = ST_KEYX;
        end else begin
          cmd.blk_init = 1'b1;
          state_next = ST_ROUND;
        end
      end
      ST_KEYX: begin
        cmd.key_step = 1'b1;
        if (stat.key_last) begin
          cmd.blk_init = 1'b1;
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.blk_round = 1'b1;
        if (stat.round_last) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### rtl/aes_cfb_dp.sv
module aes_cfb_dp
  import aes_cfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        command,
  input  logic        first,
  input  logic [63:0] data_high,
  input  logic [63:0] data_low,
  input  logic [4:0]  valid_bytes,
  output logic [63:0] result_high,
  output logic [63:0] result_low,
  output logic [4:0]  result_bytes,
  input  aes_cmd_t    cmd,
  output aes_stat_t   stat
);

  logic [63:0]  key_reg [4];
  logic [63:0]  iv_reg [2];
  logic [127:0] fb;
  logic         dec_q, first_q;
  logic [127:0] din_q;
  logic [4:0]   n_q;
  logic [63:0]  rk [30];
  // sliding window of the last eight key words
  logic [255:0] kwin;
  logic [5:0]   kidx;
  logic [127:0] st;
  logic [3:0]   rnd;
  logic [127:0] ks_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_reg <= '{default: '0};
      iv_reg <= '{default: '0};
      fb <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          3'd0: key_reg[0] <= cfg_data;
          3'd1: key_reg[1] <= cfg_data;
          3'd2: key_reg[2] <= cfg_data;
          3'd3: key_reg[3] <= cfg_data;
          3'd4: iv_reg[0] <= cfg_data;
          3'd5: iv_reg[1] <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.key_start) begin
        fb <= {iv_reg[0], iv_reg[1]};
      end
      if (cmd.finish && n_q == 5'd16) begin
        fb <= dec_q ? din_q : ks_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dec_q <= command;
      first_q <= first;
      din_q <= {data_high, data_low};
      n_q <= (valid_bytes > 5'd16) ? 5'd16 : valid_bytes;
    end
  end

  // key expansion, one 32-bit word a cycle
  logic [31:0] kt, knew;
  logic [7:0]  rc;
  always_comb begin
    kt = kwin[31:0];
    // rcon index is word index / 8 - 1
    rc = 8'h01 << (kidx[5:3] - 3'd1);
    if (kidx[2:0] == 3'd0) begin
      kt = sub_word({kt[23:0], kt[31:24]}) ^ {rc, 24'h0};
    end else if (kidx[2:0] == 3'd4) begin
      kt = sub_word(kt);
    end
    knew = kwin[255:224] ^ kt;
  end

  always_ff @(posedge clk) begin
    if (cmd.key_start) begin
      kwin <= {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
      kidx <= 6'd8;
      rk[0] <= key_reg[0];
      rk[1] <= key_reg[1];
      rk[2] <= key_reg[2];
      rk[3] <= key_reg[3];
    end else if (cmd.key_step) begin
      kwin <= {kwin[223:0], knew};
      kidx <= kidx + 6'd1;
      if (kidx[0]) begin
        rk[kidx[5:1]] <= {kwin[31:0], knew};
      end
    end
  end

  assign stat.key_last = (kidx == LastKeyWord);
  assign stat.first = first_q;
  assign stat.round_last = (rnd == LastRound);

  // one aes round a cycle
  logic [127:0] sb, mc, nxt;
  logic [127:0] rkey;
  always_comb begin
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        sb[127 - 8*(c*4+i) -: 8] = sbox(st[127 - 8*(((c+i)%4)*4+i) -: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sb[127 - 32*c -: 8];
      a1 = sb[119 - 32*c -: 8];
      a2 = sb[111 - 32*c -: 8];
      a3 = sb[103 - 32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[127 - 32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      mc[119 - 32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      mc[111 - 32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      mc[103 - 32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    rkey = {rk[{rnd, 1'b0}], rk[{rnd, 1'b1}]};
    nxt = ((rnd == LastRound) ? sb : mc) ^ rkey;
  end

  always_ff @(posedge clk) begin
    if (cmd.blk_init) begin
      st <= fb ^ {rk[0], rk[1]};
      rnd <= 4'd1;
    end else if (cmd.blk_round) begin
      st <= nxt;
      rnd <= rnd + 4'd1;
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      ks_out[127 - 8*i -: 8] = (i < n_q) ? (din_q[127 - 8*i -: 8] ^ st[127 - 8*i -: 8])
                                         : 8'h00;
    end
  end

  assign result_high = ks_out[127:64];
  assign result_low = ks_out[63:0];
  assign result_bytes = n_q;

endmodule

### rtl/aes256_cfb_cipher.sv
// channel | signals                                               | dir
// in      | in_valid in_ready command first data_high data_low   | in
//         | valid_bytes                                           |
// out     | out_valid out_ready result_high result_low            | out
//         | result_bytes                                          |
// cfg     | cfg_write cfg_index cfg_data                          | in
// one word at a time: 1 load, 1 setup, 14 rounds (one round unit), then output
// first word of a message adds key expansion (one key word a cycle)
// synchronous reset clears state, keys, iv and feedback
// a stalled output holds the block; no new word is taken until it leaves
module aes256_cfb_cipher
  import aes_cfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic        first,
  input  logic [63:0] data_high,
  input  logic [63:0] data_low,
  input  logic [4:0]  valid_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_high,
  output logic [63:0] result_low,
  output logic [4:0]  result_bytes
);

  aes_cmd_t  cmd;
  aes_stat_t stat;

  aes_cfb_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  aes_cfb_dp u_dp (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .command, .first,
    .data_high, .data_low, .valid_bytes, .result_high, .result_low,
    .result_bytes, .cmd, .stat
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input and output overlap");
  a_out_then_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> in_ready) else $error("not idle after output");
  a_bytes_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_bytes <= 5'd16) else $error("byte count too big");
`endif

endmodule

### verif/aes256_cfb_cipher_test.sv
`timescale 1ns / 100ps

module aes256_cfb_cipher_test;
  import aes_cfb_pkg::*;

  localparam logic [2:0] RegKey0 = 3'd0;
  localparam logic [2:0] RegKey1 = 3'd1;
  localparam logic [2:0] RegKey2 = 3'd2;
  localparam logic [2:0] RegKey3 = 3'd3;
  localparam logic [2:0] RegIvHigh = 3'd4;
  localparam logic [2:0] RegIvLow = 3'd5;
  localparam logic CmdEncrypt = 1'b0;
  localparam logic CmdDecrypt = 1'b1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = 1'b0;
  logic        first = 1'b0;
  logic [63:0] data_high = '0;
  logic [63:0] data_low = '0;
  logic [4:0]  valid_bytes = 5'd16;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] result_high;
  logic [63:0] result_low;
  logic [4:0]  result_bytes;

  aes256_cfb_cipher dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  count;
  } cipher_word_t;

  // sbox kept locally so the prediction does not lean on package functions
  logic [7:0] sb [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  logic [63:0]  key_reg [4];
  logic [63:0]  iv_reg [2];
  logic [127:0] sched [15];
  logic [127:0] chain;
  cipher_word_t expected_words [$];

  int  mismatches = 0;
  int  words_sent = 0;
  int  words_checked = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_off_cycles = 0;
  bit  expect_started = 1'b0;
  bit  message_open = 1'b0;

  function automatic logic [7:0] mul2(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] subst32(logic [31:0] w);
    return {sb[w[31:24]], sb[w[23:16]], sb[w[15:8]], sb[w[7:0]]};
  endfunction

  function automatic void build_schedule();
    logic [31:0] w [60];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) begin
      w[2*i] = key_reg[i][63:32];
      w[2*i+1] = key_reg[i][31:0];
    end
    for (int i = 8; i < 60; i++) begin
      t = w[i-1];
      if (i % 8 == 0) begin
        t = subst32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = mul2(rc);
      end else if (i % 8 == 4) begin
        t = subst32(t);
      end
      w[i] = w[i-8] ^ t;
    end
    for (int r = 0; r < 15; r++)
      sched[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  // byte 0 is bits 127:120 of the flat block
  function automatic logic [127:0] aes_encrypt(logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] st;
    st = blk ^ sched[0];
    for (int r = 1; r <= 14; r++) begin
      for (int i = 0; i < 16; i++) s[i] = st[127-8*i -: 8];
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[c*4+i] = sb[s[((c+i)%4)*4+i]];
      if (r < 14) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          t[c*4] = a0 ^ all ^ mul2(a0 ^ a1);
          t[c*4+1] = a1 ^ all ^ mul2(a1 ^ a2);
          t[c*4+2] = a2 ^ all ^ mul2(a2 ^ a3);
          t[c*4+3] = a3 ^ all ^ mul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[127-8*i -: 8] = t[i];
      st = st ^ sched[r];
    end
    return st;
  endfunction

  function automatic void predict_cfb(logic cmd, logic start, logic [63:0] hi,
                                      logic [63:0] lo, logic [4:0] cnt);
    logic [127:0] ks, din, dout;
    cipher_word_t w;
    int n;
    n = (cnt > 5'd16) ? 16 : int'(cnt);
    if (start) begin
      build_schedule();
      chain = {iv_reg[0], iv_reg[1]};
    end
    ks = aes_encrypt(chain);
    din = {hi, lo};
    for (int i = 0; i < 16; i++)
      dout[127-8*i -: 8] = (i < n) ? (din[127-8*i -: 8] ^ ks[127-8*i -: 8]) : 8'h00;
    if (n == 16) chain = (cmd == CmdDecrypt) ? din : dout;
    w.hi = dout[127:64];
    w.lo = dout[63:0];
    w.count = 5'(n);
    expected_words.push_back(w);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx < RegIvHigh) key_reg[idx] = val;
    else iv_reg[idx - RegIvHigh] = val;
    @(posedge clk);
  endtask

  task automatic load_key(logic [255:0] k);
    write_reg(RegKey0, k[255:192]);
    write_reg(RegKey1, k[191:128]);
    write_reg(RegKey2, k[127:64]);
    write_reg(RegKey3, k[63:0]);
  endtask

  task automatic load_iv(logic [127:0] v);
    write_reg(RegIvHigh, v[127:64]);
    write_reg(RegIvLow, v[63:0]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // send one word; caller keeps valid_bytes below 16 only on a last block
  task automatic send_word(logic cmd, logic start, logic [63:0] hi, logic [63:0] lo,
                           logic [4:0] cnt);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    first <= start;
    data_high <= hi;
    data_low <= lo;
    valid_bytes <= cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_cfb(cmd, start, hi, lo, cnt);
    words_sent++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cipher_word_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h %h", result_high, result_low);
      end else begin
        e = expected_words.pop_front();
        words_checked++;
        if (result_high !== e.hi || result_low !== e.lo || result_bytes !== e.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: expected %h %h %0d got %h %h %0d", words_checked,
                     e.hi, e.lo, e.count, result_high, result_low, result_bytes);
        end
      end
    end
  end

  task automatic test_known_vector();
    // standard aes-256 cfb128 vector
    load_key(256'h603deb1015ca71be2b73aef0857d77811f352c073b6108d72d9810a30914dff4);
    load_iv(128'h000102030405060708090a0b0c0d0e0f);
    send_word(CmdEncrypt, 1'b1, 64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16);
    send_word(CmdEncrypt, 1'b0, 64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 5'd16);
    send_word(CmdDecrypt, 1'b1, 64'hdc7e84bfda79164b, 64'h7ecd8486985d3860, 5'd16);
    send_word(CmdDecrypt, 1'b0, 64'h39ffed143b28b1c8, 64'h32113c6331e5407b, 5'd16);
    drain();
  endtask

  task automatic test_edge_fields();
    load_key('1);
    load_iv('1);
    send_word(CmdEncrypt, 1'b1, '1, '1, 5'd16);
    send_word(CmdDecrypt, 1'b0, '0, '0, 5'd16);
    send_word(CmdEncrypt, 1'b0, '1, '0, 5'd31);
    send_word(CmdEncrypt, 1'b0, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 5'd17);
    send_word(CmdEncrypt, 1'b0, '1, '1, 5'd0);
    send_word(CmdEncrypt, 1'b0, '1, '1, 5'd1);
    send_word(CmdDecrypt, 1'b1, '1, '1, 5'd15);
    drain();
    load_key('0);
    load_iv('0);
    send_word(CmdEncrypt, 1'b1, '0, '0, 5'd16);
    drain();
    // key registers change mid message: the old schedule stays in use
    load_key(256'h0123456789abcdeffedcba98765432100f1e2d3c4b5a69788796a5b4c3d2e1f0);
    send_word(CmdEncrypt, 1'b0, '1, '0, 5'd8);
    send_word(CmdEncrypt, 1'b1, '0, '1, 5'd16);
    drain();
  endtask

  task automatic random_messages(int words);
    int len;
    logic cmd;
    logic [4:0] cnt;
    while (words > 0) begin
      if ($urandom_range(3) == 0) begin
        drain();
        load_key({rand64(), rand64(), rand64(), rand64()});
        load_iv({rand64(), rand64()});
      end
      len = $urandom_range(1, 12);
      cmd = 1'($urandom);
      for (int i = 0; i < len && words > 0; i++) begin
        cnt = 5'd16;
        if (i == len - 1 && $urandom_range(2) == 0) cnt = 5'($urandom_range(0, 31));
        send_word(cmd, i == 0, rand64(), rand64(), cnt);
        words--;
      end
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_off_cycles = 400;
    send_idle_pct = 0;
    random_messages(8);
    drain();
  endtask

  initial begin
    key_reg = '{default: '0};
    iv_reg = '{default: '0};
    chain = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_known_vector();
    test_edge_fields();
    send_idle_pct = 0;  recv_stall_pct = 0;  random_messages(150);
    send_idle_pct = 59; recv_stall_pct = 0;  random_messages(150);
    send_idle_pct = 0;  recv_stall_pct = 59; random_messages(150);
    send_idle_pct = 22; recv_stall_pct = 22; random_messages(150);
    recv_stall_pct = 0;
    test_backpressure();
    $display("covered %0d words, %0d checked: known vectors, field extremes,", words_sent,
             words_checked);
    $display("short and oversized counts, key change mid message, random cfb messages");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### sim.f
rtl/aes_cfb_pkg.sv
rtl/aes_cfb_ctrl.sv
rtl/aes_cfb_dp.sv
rtl/aes256_cfb_cipher.sv
verif/aes256_cfb_cipher_test.sv
